### src/rosa_pkg.sv
// shared constants and control types for the rectangle separating-axis overlap block
// no dependencies; compiled first
`default_nettype none

package rosa_pkg;

   // default coordinate width, signed two's complement fixed point
   localparam int COORD_BITS_DEFAULT = 16;

   // corners per rectangle, in the order top right, top left, bottom right, bottom left
   localparam int RECT_CORNERS = 4;

   // separating axes checked, one lane each
   localparam int AXIS_LANES = 4;

   // operation codes
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_TEST = 1'b1;

   // corner indexes
   localparam int CORNER_TR = 0;
   localparam int CORNER_TL = 1;
   localparam int CORNER_BR = 2;
   localparam int CORNER_BL = 3;

   // load enables for the stages inside one axis lane
   typedef struct packed {
      logic prod_en;
      logic dot_en;
      logic pair_en;
      logic span_en;
   } rosa_lane_ctl_type;

endpackage

`default_nettype wire

### src/rosa_if.sv
// valid/ready channel interfaces for the request and response sides
// depends on rosa_pkg for the default coordinate width
`default_nettype none

interface rosa_req_if #(
   parameter int COORD_BITS = rosa_pkg::COORD_BITS_DEFAULT
);
   logic                         valid;
   logic                         ready;
   logic                         operation;
   logic signed [COORD_BITS-1:0] pos_x;
   logic signed [COORD_BITS-1:0] pos_y;
   logic signed [COORD_BITS-1:0] top_right_x;
   logic signed [COORD_BITS-1:0] top_right_y;
   logic signed [COORD_BITS-1:0] top_left_x;
   logic signed [COORD_BITS-1:0] top_left_y;
   logic signed [COORD_BITS-1:0] bottom_right_x;
   logic signed [COORD_BITS-1:0] bottom_right_y;
   logic signed [COORD_BITS-1:0] bottom_left_x;
   logic signed [COORD_BITS-1:0] bottom_left_y;

   modport source (
      output valid, operation, pos_x, pos_y, top_right_x, top_right_y,
             top_left_x, top_left_y, bottom_right_x, bottom_right_y,
             bottom_left_x, bottom_left_y,
      input  ready
   );

   modport sink (
      input  valid, operation, pos_x, pos_y, top_right_x, top_right_y,
             top_left_x, top_left_y, bottom_right_x, bottom_right_y,
             bottom_left_x, bottom_left_y,
      output ready
   );
endinterface

interface rosa_rsp_if;
   logic valid;
   logic ready;
   logic colliding;

   modport source (output valid, colliding, input ready);
   modport sink   (input valid, colliding, output ready);
endinterface

`default_nettype wire

### src/rosa_lane.sv
// one separating-axis lane: projects both rectangles onto one axis and checks interval overlap
// depends on rosa_pkg; stage enables come from the top level
`default_nettype none

module rosa_lane #(
   parameter int COORD_BITS = rosa_pkg::COORD_BITS_DEFAULT
) (
   input  logic                         clock,
   input  rosa_pkg::rosa_lane_ctl_type  ctl,
   input  logic signed [COORD_BITS+1:0] axis_x,
   input  logic signed [COORD_BITS+1:0] axis_y,
   input  logic signed [COORD_BITS:0]   ref_x [rosa_pkg::RECT_CORNERS],
   input  logic signed [COORD_BITS:0]   ref_y [rosa_pkg::RECT_CORNERS],
   input  logic signed [COORD_BITS:0]   tst_x [rosa_pkg::RECT_CORNERS],
   input  logic signed [COORD_BITS:0]   tst_y [rosa_pkg::RECT_CORNERS],
   output logic                         overlap
);
   import rosa_pkg::*;

   localparam int CW = COORD_BITS + 1;
   localparam int AW = COORD_BITS + 2;
   localparam int PW = CW + AW;
   localparam int DW = PW + 1;
   localparam int NC = RECT_CORNERS;
   localparam int NH = RECT_CORNERS / 2;

   // group 0 is the reference rectangle, group 1 the test rectangle
   logic signed [CW-1:0] corner_x [2][NC];
   logic signed [CW-1:0] corner_y [2][NC];

   logic signed [PW-1:0] prod_x_ff [2][NC];
   logic signed [PW-1:0] prod_y_ff [2][NC];
   logic signed [PW-1:0] prod_x_in [2][NC];
   logic signed [PW-1:0] prod_y_in [2][NC];
   logic                 zero_prod_ff;

   logic signed [DW-1:0] dot_ff [2][NC];
   logic signed [DW-1:0] dot_in [2][NC];
   logic                 zero_dot_ff;

   logic signed [DW-1:0] pmin_ff [2][NH];
   logic signed [DW-1:0] pmax_ff [2][NH];
   logic signed [DW-1:0] pmin_in [2][NH];
   logic signed [DW-1:0] pmax_in [2][NH];
   logic                 zero_pair_ff;

   logic signed [DW-1:0] smin_ff [2];
   logic signed [DW-1:0] smax_ff [2];
   logic signed [DW-1:0] smin_in [2];
   logic signed [DW-1:0] smax_in [2];
   logic                 zero_span_ff;

   always_comb begin
      for (int j = 0; j < NC; j++) begin
         corner_x[0][j] = ref_x[j];
         corner_y[0][j] = ref_y[j];
         corner_x[1][j] = tst_x[j];
         corner_y[1][j] = tst_y[j];
      end
   end

   // products of every corner coordinate with the axis
   always_comb begin
      for (int g = 0; g < 2; g++) begin
         for (int j = 0; j < NC; j++) begin
            prod_x_in[g][j] = PW'(corner_x[g][j]) * PW'(axis_x);
            prod_y_in[g][j] = PW'(corner_y[g][j]) * PW'(axis_y);
         end
      end
   end

   always_comb begin
      for (int g = 0; g < 2; g++) begin
         for (int j = 0; j < NC; j++) begin
            dot_in[g][j] = DW'(prod_x_ff[g][j]) + DW'(prod_y_ff[g][j]);
         end
      end
   end

   // first level of the min/max tree: pairs of corners
   always_comb begin
      for (int g = 0; g < 2; g++) begin
         for (int h = 0; h < NH; h++) begin
            if (dot_ff[g][2*h] < dot_ff[g][2*h+1]) begin
               pmin_in[g][h] = dot_ff[g][2*h];
               pmax_in[g][h] = dot_ff[g][2*h+1];
            end else begin
               pmin_in[g][h] = dot_ff[g][2*h+1];
               pmax_in[g][h] = dot_ff[g][2*h];
            end
         end
      end
   end

   always_comb begin
      for (int g = 0; g < 2; g++) begin
         smin_in[g] = (pmin_ff[g][0] < pmin_ff[g][1]) ? pmin_ff[g][0] : pmin_ff[g][1];
         smax_in[g] = (pmax_ff[g][0] < pmax_ff[g][1]) ? pmax_ff[g][1] : pmax_ff[g][0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.prod_en) begin
         prod_x_ff    <= prod_x_in;
         prod_y_ff    <= prod_y_in;
         zero_prod_ff <= (axis_x == '0) && (axis_y == '0);
      end
      if (ctl.dot_en) begin
         dot_ff      <= dot_in;
         zero_dot_ff <= zero_prod_ff;
      end
      if (ctl.pair_en) begin
         pmin_ff      <= pmin_in;
         pmax_ff      <= pmax_in;
         zero_pair_ff <= zero_dot_ff;
      end
      if (ctl.span_en) begin
         smin_ff      <= smin_in;
         smax_ff      <= smax_in;
         zero_span_ff <= zero_pair_ff;
      end
   end

   // bounds touching counts as overlap; a degenerate axis never does
   assign overlap = !zero_span_ff && !(smax_ff[0] < smin_ff[1]) && !(smax_ff[1] < smin_ff[0]);

endmodule

`default_nettype wire

### src/rect_overlap_separating_axis.sv
// a test transfer passes stage 0, stage 1, the lane stages and the output register before its result shows on rsp_ch
// throughput: one transfer per cycle while rsp_ch is not stalled, loads and tests alike; a load gives no response
// the rate is set by the four axis lanes, each a fully pipelined product/sum/min-max chain
// reset (synchronous, active high) empties the pipeline and clears the reference corners
// to zero, so a test before any load reports no collision
`default_nettype none

module rect_overlap_separating_axis #(
   parameter int COORD_BITS = rosa_pkg::COORD_BITS_DEFAULT
) (
   input  logic           clock,
   input  logic           reset,
   rosa_req_if.sink       req_ch,
   rosa_rsp_if.source     rsp_ch
);
   import rosa_pkg::*;

   localparam int CW     = COORD_BITS + 1;
   localparam int AW     = COORD_BITS + 2;
   localparam int NC     = RECT_CORNERS;
   localparam int NL     = AXIS_LANES;
   // stage 0 holds corners, stage 1 axes, stages 2..5 live in the lanes
   localparam int STAGES = 6;

   // --- input side: absolute corners from position plus offsets
   logic signed [COORD_BITS-1:0] off_x [NC];
   logic signed [COORD_BITS-1:0] off_y [NC];
   logic signed [CW-1:0]         in_cx [NC];
   logic signed [CW-1:0]         in_cy [NC];

   always_comb begin
      off_x[CORNER_TR] = req_ch.top_right_x;
      off_y[CORNER_TR] = req_ch.top_right_y;
      off_x[CORNER_TL] = req_ch.top_left_x;
      off_y[CORNER_TL] = req_ch.top_left_y;
      off_x[CORNER_BR] = req_ch.bottom_right_x;
      off_y[CORNER_BR] = req_ch.bottom_right_y;
      off_x[CORNER_BL] = req_ch.bottom_left_x;
      off_y[CORNER_BL] = req_ch.bottom_left_y;
      for (int i = 0; i < NC; i++) begin
         in_cx[i] = CW'(req_ch.pos_x) + CW'(off_x[i]);
         in_cy[i] = CW'(req_ch.pos_y) + CW'(off_y[i]);
      end
   end

   // --- pipeline flow control: a stage loads when it is empty or its successor loads
   logic [STAGES-1:0] stage_v_ff;
   logic [STAGES-1:0] stage_v_in;
   logic [STAGES-1:0] stage_ld;
   logic              out_v_ff;
   logic              out_v_in;
   logic              out_ld;
   logic              colliding_ff;
   logic              req_xfer;

   assign out_ld = !out_v_ff || rsp_ch.ready;

   always_comb begin
      stage_ld[STAGES-1] = !stage_v_ff[STAGES-1] || out_ld;
      for (int k = STAGES - 2; k >= 0; k--) begin
         stage_ld[k] = !stage_v_ff[k] || stage_ld[k+1];
      end
   end

   assign req_ch.ready = stage_ld[0];
   assign req_xfer     = req_ch.valid && stage_ld[0];

   // only tests travel down the pipeline; loads end at the reference store
   always_comb begin
      stage_v_in = stage_v_ff;
      if (stage_ld[0]) begin
         stage_v_in[0] = req_xfer && (req_ch.operation == OP_TEST);
      end
      for (int k = 1; k < STAGES; k++) begin
         if (stage_ld[k]) begin
            stage_v_in[k] = stage_v_ff[k-1];
         end
      end
      out_v_in = out_ld ? stage_v_ff[STAGES-1] : out_v_ff;
   end

   // --- reference rectangle store
   logic signed [CW-1:0] ref_x_ff [NC];
   logic signed [CW-1:0] ref_y_ff [NC];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NC; i++) begin
            ref_x_ff[i] <= '0;
            ref_y_ff[i] <= '0;
         end
      end else if (req_xfer && (req_ch.operation == OP_LOAD)) begin
         ref_x_ff <= in_cx;
         ref_y_ff <= in_cy;
      end
   end

   // --- stage 0: both corner sets; the reference is copied so later loads do not disturb it
   logic signed [CW-1:0] s0_rx_ff [NC];
   logic signed [CW-1:0] s0_ry_ff [NC];
   logic signed [CW-1:0] s0_tx_ff [NC];
   logic signed [CW-1:0] s0_ty_ff [NC];

   always_ff @(posedge clock) begin
      if (stage_ld[0]) begin
         s0_rx_ff <= ref_x_ff;
         s0_ry_ff <= ref_y_ff;
         s0_tx_ff <= in_cx;
         s0_ty_ff <= in_cy;
      end
   end

   // --- stage 1: the four axes, two from each rectangle's edges
   logic signed [AW-1:0] ax_in [NL];
   logic signed [AW-1:0] ay_in [NL];
   logic signed [AW-1:0] s1_ax_ff [NL];
   logic signed [AW-1:0] s1_ay_ff [NL];
   logic signed [CW-1:0] s1_rx_ff [NC];
   logic signed [CW-1:0] s1_ry_ff [NC];
   logic signed [CW-1:0] s1_tx_ff [NC];
   logic signed [CW-1:0] s1_ty_ff [NC];

   always_comb begin
      // reference top edge and right edge
      ax_in[0] = AW'(s0_rx_ff[CORNER_TR]) - AW'(s0_rx_ff[CORNER_TL]);
      ay_in[0] = AW'(s0_ry_ff[CORNER_TR]) - AW'(s0_ry_ff[CORNER_TL]);
      ax_in[1] = AW'(s0_rx_ff[CORNER_TR]) - AW'(s0_rx_ff[CORNER_BR]);
      ay_in[1] = AW'(s0_ry_ff[CORNER_TR]) - AW'(s0_ry_ff[CORNER_BR]);
      // test shape left edge and bottom edge
      ax_in[2] = AW'(s0_tx_ff[CORNER_BL]) - AW'(s0_tx_ff[CORNER_TL]);
      ay_in[2] = AW'(s0_ty_ff[CORNER_BL]) - AW'(s0_ty_ff[CORNER_TL]);
      ax_in[3] = AW'(s0_tx_ff[CORNER_BL]) - AW'(s0_tx_ff[CORNER_BR]);
      ay_in[3] = AW'(s0_ty_ff[CORNER_BL]) - AW'(s0_ty_ff[CORNER_BR]);
   end

   always_ff @(posedge clock) begin
      if (stage_ld[1]) begin
         s1_ax_ff <= ax_in;
         s1_ay_ff <= ay_in;
         s1_rx_ff <= s0_rx_ff;
         s1_ry_ff <= s0_ry_ff;
         s1_tx_ff <= s0_tx_ff;
         s1_ty_ff <= s0_ty_ff;
      end
   end

   // --- stages 2..5: one lane per axis
   rosa_lane_ctl_type lane_ctl;
   logic [NL-1:0]     lane_overlap;

   assign lane_ctl.prod_en = stage_ld[2];
   assign lane_ctl.dot_en  = stage_ld[3];
   assign lane_ctl.pair_en = stage_ld[4];
   assign lane_ctl.span_en = stage_ld[5];

   for (genvar l = 0; l < NL; l++) begin : g_lane
      rosa_lane #(
         .COORD_BITS (COORD_BITS)
      ) u_lane (
         .clock   (clock),
         .ctl     (lane_ctl),
         .axis_x  (s1_ax_ff[l]),
         .axis_y  (s1_ay_ff[l]),
         .ref_x   (s1_rx_ff),
         .ref_y   (s1_ry_ff),
         .tst_x   (s1_tx_ff),
         .tst_y   (s1_ty_ff),
         .overlap (lane_overlap[l])
      );
   end

   // --- merge: collision only when no lane found a separating axis
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_v_ff <= '0;
         out_v_ff   <= 1'b0;
      end else begin
         stage_v_ff <= stage_v_in;
         out_v_ff   <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ld) begin
         colliding_ff <= &lane_overlap;
      end
   end

   assign rsp_ch.valid     = out_v_ff;
   assign rsp_ch.colliding = colliding_ff;

endmodule

`default_nettype wire

### src/rosa_checker.sv
// port-level checks for the rectangle overlap block, bound to the top level
// depends on rosa_pkg for the operation codes and on the top level's channel ports
`default_nettype none

module rosa_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic req_operation,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic rsp_colliding
);
   import rosa_pkg::*;

   // tests in flight: six pipeline stages plus the output register
   localparam int CAPACITY = 7;

   logic [3:0] pending_ff;
   logic [3:0] pending_in;
   logic       test_xfer;
   logic       rsp_xfer;

   assign test_xfer = req_valid && req_ready && (req_operation == OP_TEST);
   assign rsp_xfer  = rsp_valid && rsp_ready;

   always_comb begin
      pending_in = pending_ff;
      if (test_xfer && !rsp_xfer) begin
         pending_in = pending_ff + 4'd1;
      end else if (!test_xfer && rsp_xfer) begin
         pending_in = pending_ff - 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped before transfer");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_colliding))
      else $error("stalled response changed");

   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 4'd0)
      else $error("response without an outstanding test");

   a_capacity: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= 4'(CAPACITY))
      else $error("more tests in flight than pipeline capacity");

   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (pending_ff == 4'(CAPACITY)) && !rsp_ready |-> !req_ready)
      else $error("request accepted while pipeline full and stalled");

endmodule

bind rect_overlap_separating_axis rosa_checker u_rosa_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .req_operation (req_ch.operation),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_colliding (rsp_ch.colliding)
);

`default_nettype wire

### tb/rect_overlap_checker.sv
`timescale 1ns / 1ps
// collision checker for the rectangle separating-axis block: predicts every test transfer
// and compares the flag on the response channel; depends on rosa_pkg and rosa_if
module rect_overlap_checker #(
   parameter int COORD_BITS = rosa_pkg::COORD_BITS_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   rosa_req_if  req_ch,
   rosa_rsp_if  rsp_ch,
   output int   miscompares,
   output int   pending
);
   import rosa_pkg::*;

   typedef logic signed [COORD_BITS:0]     corner_type;
   typedef logic signed [COORD_BITS+1:0]   axis_type;
   typedef logic signed [2*COORD_BITS+4:0] proj_type;
   typedef corner_type quad_type [RECT_CORNERS];

   quad_type ref_x, ref_y, shape_x, shape_y;
   logic     colliding_due [$];
   logic     due;

   // min and max of the exact projections of four corners onto one axis
   function automatic void project_span(input quad_type xs, input quad_type ys,
                                        input axis_type ax, input axis_type ay,
                                        output proj_type lo, output proj_type hi);
      proj_type d;
      for (int j = 0; j < RECT_CORNERS; j++) begin
         d = proj_type'(xs[j]) * proj_type'(ax) + proj_type'(ys[j]) * proj_type'(ay);
         if (j == 0 || d < lo) lo = d;
         if (j == 0 || d > hi) hi = d;
      end
   endfunction

   function automatic logic sat_overlap(input quad_type rx, ry, tx, ty);
      axis_type ax [AXIS_LANES];
      axis_type ay [AXIS_LANES];
      proj_type ref_lo, ref_hi, tst_lo, tst_hi;
      // reference top and right edges, then test left and bottom edges
      ax[0] = axis_type'(rx[CORNER_TR]) - axis_type'(rx[CORNER_TL]);
      ay[0] = axis_type'(ry[CORNER_TR]) - axis_type'(ry[CORNER_TL]);
      ax[1] = axis_type'(rx[CORNER_TR]) - axis_type'(rx[CORNER_BR]);
      ay[1] = axis_type'(ry[CORNER_TR]) - axis_type'(ry[CORNER_BR]);
      ax[2] = axis_type'(tx[CORNER_BL]) - axis_type'(tx[CORNER_TL]);
      ay[2] = axis_type'(ty[CORNER_BL]) - axis_type'(ty[CORNER_TL]);
      ax[3] = axis_type'(tx[CORNER_BL]) - axis_type'(tx[CORNER_BR]);
      ay[3] = axis_type'(ty[CORNER_BL]) - axis_type'(ty[CORNER_BR]);
      for (int i = 0; i < AXIS_LANES; i++) begin
         if (ax[i] == 0 && ay[i] == 0) return 1'b0;
         project_span(rx, ry, ax[i], ay[i], ref_lo, ref_hi);
         project_span(tx, ty, ax[i], ay[i], tst_lo, tst_hi);
         if (ref_hi < tst_lo || tst_hi < ref_lo) return 1'b0;
      end
      return 1'b1;
   endfunction

   task automatic log_miss(input string what);
      miscompares++;
      if (miscompares <= 10) $display("[%0t] mismatch: %s", $time, what);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         foreach (ref_x[i]) begin
            ref_x[i] = '0;
            ref_y[i] = '0;
         end
         colliding_due.delete();
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (colliding_due.size() == 0) begin
               log_miss($sformatf("expected none, got colliding=%b", rsp_ch.colliding));
            end else begin
               due = colliding_due.pop_front();
               if (rsp_ch.colliding !== due)
                  log_miss($sformatf("expected colliding=%b, got %b", due, rsp_ch.colliding));
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            shape_x[CORNER_TR] = corner_type'(req_ch.pos_x) + corner_type'(req_ch.top_right_x);
            shape_y[CORNER_TR] = corner_type'(req_ch.pos_y) + corner_type'(req_ch.top_right_y);
            shape_x[CORNER_TL] = corner_type'(req_ch.pos_x) + corner_type'(req_ch.top_left_x);
            shape_y[CORNER_TL] = corner_type'(req_ch.pos_y) + corner_type'(req_ch.top_left_y);
            shape_x[CORNER_BR] = corner_type'(req_ch.pos_x)
                               + corner_type'(req_ch.bottom_right_x);
            shape_y[CORNER_BR] = corner_type'(req_ch.pos_y)
                               + corner_type'(req_ch.bottom_right_y);
            shape_x[CORNER_BL] = corner_type'(req_ch.pos_x)
                               + corner_type'(req_ch.bottom_left_x);
            shape_y[CORNER_BL] = corner_type'(req_ch.pos_y)
                               + corner_type'(req_ch.bottom_left_y);
            if (req_ch.operation == OP_LOAD) begin
               ref_x = shape_x;
               ref_y = shape_y;
            end else begin
               colliding_due.push_back(sat_overlap(ref_x, ref_y, shape_x, shape_y));
            end
         end
      end
      pending = colliding_due.size();
   end
endmodule

### tb/tb_rect_overlap_separating_axis.sv
`timescale 1ns / 1ps
// top of the rectangle separating-axis testbench: clock, reset, stimulus, stalls, verdict
// depends on rosa_pkg, rosa_if, the block and rect_overlap_checker
module tb_rect_overlap_separating_axis;
   import rosa_pkg::*;

   localparam int CW           = COORD_BITS_DEFAULT;
   localparam int RANDOM_ITEMS = 1230;
   // no transfer on either side for this long means the block is stuck
   localparam int IDLE_LIMIT   = 2000;
   // after the drain, leave a margin for stray responses
   localparam int TAIL_CYCLES  = 24;

   typedef logic signed [CW-1:0] coord_type;

   typedef struct {
      logic      op;
      coord_type pos_x, pos_y;
      coord_type tr_x, tr_y, tl_x, tl_y, br_x, br_y, bl_x, bl_y;
   } rect_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   miscompares;
   int   pending;
   int   idle_cycles = 0;
   int   rsp_hold = 0;
   bit   calm = 1'b0;

   // reference as last loaded by a well-formed load, used to aim tests at it
   int   ref_cx = 0;
   int   ref_cy = 0;
   int   ref_span = 100;

   always #4 clock = ~clock;

   rosa_req_if #(.COORD_BITS(CW)) req_ch ();
   rosa_rsp_if                    rsp_ch ();

   rect_overlap_separating_axis #(.COORD_BITS(CW)) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   rect_overlap_checker #(.COORD_BITS(CW)) u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .miscompares (miscompares),
      .pending     (pending)
   );

   // mostly no gap, some short ones, a few long; none at all in a calm stretch
   function automatic int pick_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 15);
      return $urandom_range(16, 60);
   endfunction

   // rough extent of a rectangle, mostly modest, sometimes near the coordinate range
   function automatic int pick_size();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) return $urandom_range(8, 2000);
      if (r < 95) return $urandom_range(2000, 8000);
      return $urandom_range(8000, 16000);
   endfunction

   function automatic int clamp_coord(input int v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   // centered rectangle from edge vectors e1 and e2: e1 runs bottom left to bottom right,
   // e2 runs bottom left to top left
   function automatic rect_item_type make_rect(input logic op, input int px, input int py,
                                               input int e1x, input int e1y,
                                               input int e2x, input int e2y);
      rect_item_type it;
      int ox, oy;
      ox = -(e1x + e2x) / 2;
      oy = -(e1y + e2y) / 2;
      it.op    = op;
      it.pos_x = coord_type'(px);
      it.pos_y = coord_type'(py);
      it.bl_x  = coord_type'(ox);
      it.bl_y  = coord_type'(oy);
      it.br_x  = coord_type'(ox + e1x);
      it.br_y  = coord_type'(oy + e1y);
      it.tl_x  = coord_type'(ox + e2x);
      it.tl_y  = coord_type'(oy + e2y);
      it.tr_x  = coord_type'(ox + e1x + e2x);
      it.tr_y  = coord_type'(oy + e1y + e2y);
      return it;
   endfunction

   function automatic rect_item_type all_fields(input logic op, input coord_type v);
      rect_item_type it;
      it = '{op, v, v, v, v, v, v, v, v, v, v};
      return it;
   endfunction

   // rotated rectangle: direction on a small integer grid keeps the edges exactly square
   function automatic rect_item_type random_rect(input logic op, input int cx, input int cy,
                                                 input int span);
      int ux, uy, w, h;
      do begin
         ux = int'($urandom_range(0, 16)) - 8;
         uy = int'($urandom_range(0, 16)) - 8;
      end while (ux == 0 && uy == 0);
      w = $urandom_range(1, span / 8);
      h = $urandom_range(1, span / 8);
      return make_rect(op, cx, cy, ux * w, uy * w, -uy * h, ux * h);
   endfunction

   function automatic rect_item_type noise_item();
      rect_item_type it;
      it.op    = $urandom_range(0, 1) ? OP_TEST : OP_LOAD;
      it.pos_x = coord_type'($urandom);
      it.pos_y = coord_type'($urandom);
      it.tr_x  = coord_type'($urandom);
      it.tr_y  = coord_type'($urandom);
      it.tl_x  = coord_type'($urandom);
      it.tl_y  = coord_type'($urandom);
      it.br_x  = coord_type'($urandom);
      it.br_y  = coord_type'($urandom);
      it.bl_x  = coord_type'($urandom);
      it.bl_y  = coord_type'($urandom);
      return it;
   endfunction

   // test shape placed around the current reference
   function automatic rect_item_type near_test(input logic op);
      int dx, dy;
      dx = int'($urandom_range(0, 2 * ref_span)) - ref_span;
      dy = int'($urandom_range(0, 2 * ref_span)) - ref_span;
      return random_rect(op, clamp_coord(ref_cx + dx), clamp_coord(ref_cy + dy),
                         $urandom_range(8, ref_span + 8));
   endfunction

   // one request transfer; valid only drops when a gap follows
   task automatic push_item(input rect_item_type it);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.operation      <= it.op;
      req_ch.pos_x          <= it.pos_x;
      req_ch.pos_y          <= it.pos_y;
      req_ch.top_right_x    <= it.tr_x;
      req_ch.top_right_y    <= it.tr_y;
      req_ch.top_left_x     <= it.tl_x;
      req_ch.top_left_y     <= it.tl_y;
      req_ch.bottom_right_x <= it.br_x;
      req_ch.bottom_right_y <= it.br_y;
      req_ch.bottom_left_x  <= it.bl_x;
      req_ch.bottom_left_y  <= it.bl_y;
      req_ch.valid          <= 1'b1;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
   endtask

   // response side backpressure, random stall runs
   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_ch.ready <= 1'b0;
         rsp_hold--;
      end else begin
         rsp_ch.ready <= 1'b1;
         if ($urandom_range(0, 3) == 0) rsp_hold = pick_gap();
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      rect_item_type item;
      int            sel;

      req_ch.valid = 1'b0;
      req_ch.operation = OP_LOAD;
      req_ch.pos_x = '0;
      req_ch.pos_y = '0;
      req_ch.top_right_x = '0;
      req_ch.top_right_y = '0;
      req_ch.top_left_x = '0;
      req_ch.top_left_y = '0;
      req_ch.bottom_right_x = '0;
      req_ch.bottom_right_y = '0;
      req_ch.bottom_left_x = '0;
      req_ch.bottom_left_y = '0;
      rsp_ch.ready = 1'b0;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // ---- directed part ----
      // test before any load sees the all-zero reference, whose axes have no length
      push_item(make_rect(OP_TEST, 0, 0, 100, 0, 0, 50));
      push_item(all_fields(OP_TEST, coord_type'(16'sh8000)));

      // axis-aligned square spanning -50..50 on both axes
      push_item(make_rect(OP_LOAD, 0, 0, 100, 0, 0, 100));
      push_item(make_rect(OP_TEST, 0, 0, 100, 0, 0, 100));
      // edges touching count as overlap, one step further apart does not
      push_item(make_rect(OP_TEST, 100, 0, 100, 0, 0, 100));
      push_item(make_rect(OP_TEST, 101, 0, 100, 0, 0, 100));
      push_item(make_rect(OP_TEST, 0, -100, 100, 0, 0, 100));
      push_item(make_rect(OP_TEST, 0, -101, 100, 0, 0, 100));
      // diamond whose bounding box overlaps the square but a diagonal axis separates
      push_item(make_rect(OP_TEST, 95, 95, 50, 50, -50, 50));
      push_item(make_rect(OP_TEST, 70, 70, 50, 50, -50, 50));

      // zero-length test edges: left edge, then bottom edge
      item = make_rect(OP_TEST, 0, 0, 60, 0, 0, 60);
      item.tl_x = item.bl_x;
      item.tl_y = item.bl_y;
      push_item(item);
      item = make_rect(OP_TEST, 0, 0, 60, 0, 0, 60);
      item.br_x = item.bl_x;
      item.br_y = item.bl_y;
      push_item(item);

      // field extremes against a real reference
      push_item(all_fields(OP_TEST, coord_type'(16'sh8000)));
      push_item(all_fields(OP_TEST, coord_type'(16'sh7fff)));

      // reference collapsed to one point at the most negative corner
      push_item(all_fields(OP_LOAD, coord_type'(16'sh8000)));
      push_item(make_rect(OP_TEST, 0, 0, 100, 0, 0, 100));

      // degenerate reference: top edge has no length
      item = make_rect(OP_LOAD, 0, 0, 100, 0, 0, 100);
      item.tr_x = item.tl_x;
      item.tr_y = item.tl_y;
      push_item(item);
      push_item(make_rect(OP_TEST, 0, 0, 100, 0, 0, 100));

      // huge reference with the position and every corner offset at a field extreme
      item = '{OP_LOAD, coord_type'(16'sh8000), coord_type'(16'sh7fff),
               coord_type'(16'sh7fff), coord_type'(16'sh7fff),
               coord_type'(16'sh8000), coord_type'(16'sh7fff),
               coord_type'(16'sh7fff), coord_type'(16'sh8000),
               coord_type'(16'sh8000), coord_type'(16'sh8000)};
      push_item(item);
      push_item(make_rect(OP_TEST, 0, 0, 100, 0, 0, 100));
      item.op = OP_TEST;
      push_item(item);
      item = '{OP_TEST, coord_type'(16'sh7fff), coord_type'(16'sh8000),
               coord_type'(16'sh8000), coord_type'(16'sh8000),
               coord_type'(16'sh7fff), coord_type'(16'sh8000),
               coord_type'(16'sh8000), coord_type'(16'sh7fff),
               coord_type'(16'sh7fff), coord_type'(16'sh7fff)};
      push_item(item);

      // ---- random part ----
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         // calm stretches run at full rate on both sides
         if (n % 100 == 0) calm = ($urandom_range(0, 3) == 0);
         // hold off until every pending result has been returned
         if (n % 300 == 150) begin
            req_ch.valid <= 1'b0;
            do @(negedge clock); while (pending != 0);
         end
         sel = $urandom_range(0, 99);
         if (sel < 10) begin
            ref_span = pick_size();
            ref_cx   = int'($urandom_range(0, 60000)) - 30000;
            ref_cy   = int'($urandom_range(0, 60000)) - 30000;
            item     = random_rect(OP_LOAD, ref_cx, ref_cy, ref_span);
         end else if (sel < 78) begin
            item = near_test(OP_TEST);
         end else if (sel < 86) begin
            item = noise_item();
         end else if (sel < 94) begin
            // collapse one of the edges the block takes an axis from
            item = near_test($urandom_range(0, 1) ? OP_TEST : OP_LOAD);
            if (item.op == OP_TEST && $urandom_range(0, 1)) begin
               item.tl_x = item.bl_x;
               item.tl_y = item.bl_y;
            end else if (item.op == OP_TEST) begin
               item.br_x = item.bl_x;
               item.br_y = item.bl_y;
            end else if ($urandom_range(0, 1)) begin
               item.tl_x = item.tr_x;
               item.tl_y = item.tr_y;
            end else begin
               item.br_x = item.tr_x;
               item.br_y = item.tr_y;
            end
         end else begin
            // skewed quad: one corner moved anywhere
            item = near_test(OP_TEST);
            case ($urandom_range(0, 3))
               0: begin
                  item.tr_x = coord_type'($urandom);
                  item.tr_y = coord_type'($urandom);
               end
               1: begin
                  item.tl_x = coord_type'($urandom);
                  item.tl_y = coord_type'($urandom);
               end
               2: begin
                  item.br_x = coord_type'($urandom);
                  item.br_y = coord_type'($urandom);
               end
               default: begin
                  item.bl_x = coord_type'($urandom);
                  item.bl_y = coord_type'($urandom);
               end
            endcase
         end
         push_item(item);
      end
      req_ch.valid <= 1'b0;

      // drain, then give stray responses time to show up
      while (pending != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);

      if (miscompares == 0 && pending == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end
endmodule

### sim.f
src/rosa_pkg.sv
src/rosa_if.sv
src/rosa_lane.sv
src/rect_overlap_separating_axis.sv
src/rosa_checker.sv
tb/rect_overlap_checker.sv
tb/tb_rect_overlap_separating_axis.sv
